FILE: rtl/i2c_ras_pkg.sv
package i2c_ras_pkg;

    // Command codes carried by the cmd field of an input item.
    localparam logic [1:0] CMD_START_WRITE = 2'd0;
    localparam logic [1:0] CMD_START_READ  = 2'd1;
    localparam logic [1:0] CMD_LOAD_BYTE   = 2'd2;
    localparam logic [1:0] CMD_BUS_EVENT   = 2'd3;

    // One input item as held in the input register.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] load_index;
        logic [7:0] load_byte;
        logic       flag_start_sent;
        logic       flag_addr_acked;
        logic       flag_tx_empty;
        logic       flag_rx_full;
        logic [7:0] rx_byte;
    } t_item;

    // One result item.
    typedef struct packed {
        logic       gen_start;
        logic       gen_stop;
        logic       send_valid;
        logic [7:0] send_data;
        logic       clear_addr;
        logic       nack_next;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       write_done;
        logic       read_done;
        logic       busy_res;
    } t_result;

    // Write store access: one write and the read address for the next cycle.
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } t_store_req;

endpackage

FILE: rtl/i2c_register_access_sequencer.sv
// I2C register access sequencer. Each command (start write, start read, load
// write byte) or bus event item gives exactly one result item describing the
// bus action to take: START/STOP, a byte to send, address flag clear, NACK
// arming, a delivered read byte, done pulses and the busy state. One item is
// accepted every clock cycle while results are taken; an item passes an input
// register and then a result register, and its result can be taken once it is
// presented with o_valid, while i_stall is low. The write store is a
// STORE_DEPTH x 8 memory with a registered read port that always presents the
// slot under the store pointer, with write-through for a load to that same
// slot. The store needs no clearing after reset; write every slot a transfer
// will send before starting it.
module i2c_register_access_sequencer import i2c_ras_pkg::*; #(
    parameter int STORE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_dev_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_length,
    input  logic [7:0] i_load_index,
    input  logic [7:0] i_load_byte,
    input  logic       i_flag_start_sent,
    input  logic       i_flag_addr_acked,
    input  logic       i_flag_tx_empty,
    input  logic       i_flag_rx_full,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_gen_start,
    output logic       o_gen_stop,
    output logic       o_send_valid,
    output logic [7:0] o_send_data,
    output logic       o_clear_addr,
    output logic       o_nack_next,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_data,
    output logic       o_write_done,
    output logic       o_read_done,
    output logic       o_busy_res
);

    logic       r_in_valid;
    t_item      r_item;
    logic       r_out_valid;
    t_result    r_result;
    logic       w_advance;
    logic       w_fire;
    t_result    w_result;
    t_store_req w_store_req;
    logic [7:0] w_rd_data;

    // The processing stage moves when the result register is free or drains.
    assign w_advance = !r_out_valid || !i_stall;
    assign w_fire    = r_in_valid && w_advance;
    assign o_stall   = r_in_valid && !w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item.cmd             <= i_cmd;
            r_item.dev_addr        <= i_dev_addr;
            r_item.reg_addr        <= i_reg_addr;
            r_item.length          <= i_length;
            r_item.load_index      <= i_load_index;
            r_item.load_byte       <= i_load_byte;
            r_item.flag_start_sent <= i_flag_start_sent;
            r_item.flag_addr_acked <= i_flag_addr_acked;
            r_item.flag_tx_empty   <= i_flag_tx_empty;
            r_item.flag_rx_full    <= i_flag_rx_full;
            r_item.rx_byte         <= i_rx_byte;
        end
    end

    i2c_ras_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_item),
        .i_rd_data   (w_rd_data),
        .o_result    (w_result),
        .o_store_req (w_store_req)
    );

    i2c_ras_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (w_store_req),
        .o_rd_data (w_rd_data)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_gen_start  = r_result.gen_start;
    assign o_gen_stop   = r_result.gen_stop;
    assign o_send_valid = r_result.send_valid;
    assign o_send_data  = r_result.send_data;
    assign o_clear_addr = r_result.clear_addr;
    assign o_nack_next  = r_result.nack_next;
    assign o_rx_valid   = r_result.rx_valid;
    assign o_rx_data    = r_result.rx_data;
    assign o_write_done = r_result.write_done;
    assign o_read_done  = r_result.read_done;
    assign o_busy_res   = r_result.busy_res;

endmodule

FILE: rtl/i2c_ras_store.sv
module i2c_ras_store import i2c_ras_pkg::*; #(
    parameter int STORE_DEPTH = 256
) (
    input  logic       i_clk,
    input  t_store_req i_req,
    output logic [7:0] o_rd_data
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0]    r_mem [STORE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;

    assign w_waddr = i_req.waddr[AW-1:0];
    assign w_raddr = i_req.raddr[AW-1:0];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[w_waddr] <= i_req.wdata;
        end
    end

    // Registered read with write-through, so the data always matches the
    // slot that the store pointer selects in the current cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.we && (w_waddr == w_raddr)) begin
            r_rd_data <= i_req.wdata;
        end else begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/i2c_ras_ctrl.sv
module i2c_ras_ctrl import i2c_ras_pkg::*; #(
    parameter int STORE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_item      i_item,
    input  logic [7:0] i_rd_data,
    output t_result    o_result,
    output t_store_req o_store_req
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_SEND_DEV  = 3'd1;
    localparam logic [2:0] PH_SEND_REG  = 3'd2;
    localparam logic [2:0] PH_AFTER_REG = 3'd3;
    localparam logic [2:0] PH_SEND_DEVR = 3'd4;
    localparam logic [2:0] PH_RD_ADDR   = 3'd5;
    localparam logic [2:0] PH_RD_DATA   = 3'd6;

    logic [2:0]    r_phase,        n_phase;
    logic          r_is_read,      n_is_read;
    logic [7:0]    r_device_byte,  n_device_byte;
    logic [7:0]    r_register_ptr, n_register_ptr;
    logic [7:0]    r_bytes_left,   n_bytes_left;
    logic [7:0]    r_store_ptr,    n_store_ptr;
    logic [AW-1:0] r_store_idx,    n_store_idx;
    logic          r_active,       n_active;

    logic [7:0]    w_left_dec;
    logic          w_load_ok;
    logic [AW-1:0] w_idx_inc;

    assign w_left_dec = r_bytes_left - 8'd1;
    assign w_load_ok  = ({1'b0, i_item.load_index} < 9'(STORE_DEPTH));

    // Next store slot: the pointer wraps at 256 and the slot
    // wraps at the store depth.
    always_comb begin
        if (r_store_ptr == 8'hFF) begin
            w_idx_inc = '0;
        end else if (r_store_idx == AW'(STORE_DEPTH - 1)) begin
            w_idx_inc = '0;
        end else begin
            w_idx_inc = r_store_idx + AW'(1);
        end
    end

    // Sequencer: one action for each command or bus event.
    always_comb begin
        n_phase        = r_phase;
        n_is_read      = r_is_read;
        n_device_byte  = r_device_byte;
        n_register_ptr = r_register_ptr;
        n_bytes_left   = r_bytes_left;
        n_store_ptr    = r_store_ptr;
        n_store_idx    = r_store_idx;
        n_active       = r_active;
        o_result       = '0;
        o_store_req.we    = 1'b0;
        o_store_req.waddr = i_item.load_index;
        o_store_req.wdata = i_item.load_byte;

        case (i_item.cmd)
            CMD_START_WRITE, CMD_START_READ: begin
                n_device_byte      = i_item.dev_addr;
                n_register_ptr     = i_item.reg_addr;
                n_bytes_left       = i_item.length;
                n_store_ptr        = 8'd0;
                n_store_idx        = '0;
                n_is_read          = (i_item.cmd == CMD_START_READ);
                n_phase            = PH_SEND_DEV;
                n_active           = 1'b1;
                o_result.gen_start = 1'b1;
            end
            CMD_LOAD_BYTE: begin
                o_store_req.we = w_load_ok;
            end
            default: begin
                if (r_active) begin
                    case (r_phase)
                        PH_SEND_DEV: begin
                            if (i_item.flag_start_sent) begin
                                o_result.send_valid = 1'b1;
                                o_result.send_data  = r_device_byte;
                                n_phase             = PH_SEND_REG;
                            end
                        end
                        PH_SEND_REG: begin
                            if (i_item.flag_addr_acked) begin
                                o_result.clear_addr = 1'b1;
                                o_result.send_valid = 1'b1;
                                o_result.send_data  = r_register_ptr;
                                n_phase             = PH_AFTER_REG;
                            end
                        end
                        PH_AFTER_REG: begin
                            if (i_item.flag_tx_empty) begin
                                if (r_is_read) begin
                                    o_result.gen_start = 1'b1;
                                    n_phase            = PH_SEND_DEVR;
                                end else if (r_bytes_left != 8'd0) begin
                                    o_result.send_valid = 1'b1;
                                    o_result.send_data  = i_rd_data;
                                    n_store_ptr         = r_store_ptr + 8'd1;
                                    n_store_idx         = w_idx_inc;
                                    n_bytes_left        = w_left_dec;
                                    // More bytes: restart at the next register.
                                    if (w_left_dec != 8'd0) begin
                                        n_register_ptr     = r_register_ptr + 8'd1;
                                        n_phase            = PH_SEND_DEV;
                                        o_result.gen_start = 1'b1;
                                    end
                                end else begin
                                    o_result.write_done = 1'b1;
                                    o_result.gen_stop   = 1'b1;
                                    n_phase             = PH_IDLE;
                                    n_active            = 1'b0;
                                end
                            end
                        end
                        PH_SEND_DEVR: begin
                            if (i_item.flag_start_sent) begin
                                o_result.send_valid = 1'b1;
                                o_result.send_data  = r_device_byte | 8'h01;
                                n_phase             = PH_RD_ADDR;
                            end
                        end
                        PH_RD_ADDR: begin
                            if (i_item.flag_addr_acked) begin
                                o_result.clear_addr = 1'b1;
                                n_phase             = PH_RD_DATA;
                            end
                        end
                        PH_RD_DATA: begin
                            if (i_item.flag_rx_full) begin
                                o_result.nack_next = (r_bytes_left == 8'd1);
                                if (r_bytes_left != 8'd0) begin
                                    o_result.rx_valid = 1'b1;
                                    o_result.rx_data  = i_item.rx_byte;
                                    n_bytes_left      = w_left_dec;
                                end
                                // Finish on the last byte, and at once for an
                                // empty read.
                                if (r_bytes_left == 8'd0 || w_left_dec == 8'd0) begin
                                    o_result.read_done = 1'b1;
                                    o_result.gen_stop  = 1'b1;
                                    n_phase            = PH_IDLE;
                                    n_active           = 1'b0;
                                end else begin
                                    n_register_ptr     = r_register_ptr + 8'd1;
                                    n_phase            = PH_SEND_DEV;
                                    o_result.gen_start = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_phase  = PH_IDLE;
                            n_active = 1'b0;
                        end
                    endcase
                end
            end
        endcase

        o_result.busy_res = n_active;

        // Nothing changes unless an item is processed in this cycle.
        if (!i_fire) begin
            n_phase        = r_phase;
            n_is_read      = r_is_read;
            n_device_byte  = r_device_byte;
            n_register_ptr = r_register_ptr;
            n_bytes_left   = r_bytes_left;
            n_store_ptr    = r_store_ptr;
            n_store_idx    = r_store_idx;
            n_active       = r_active;
            o_store_req.we = 1'b0;
        end

        o_store_req.raddr = 8'(n_store_idx);
    end

    // Transfer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_is_read      <= 1'b0;
            r_device_byte  <= 8'd0;
            r_register_ptr <= 8'd0;
            r_bytes_left   <= 8'd0;
            r_store_ptr    <= 8'd0;
            r_store_idx    <= '0;
            r_active       <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_is_read      <= n_is_read;
            r_device_byte  <= n_device_byte;
            r_register_ptr <= n_register_ptr;
            r_bytes_left   <= n_bytes_left;
            r_store_ptr    <= n_store_ptr;
            r_store_idx    <= n_store_idx;
            r_active       <= n_active;
        end
    end

endmodule

FILE: bench/i2c_register_access_sequencer_test.sv
module i2c_register_access_sequencer_test import i2c_ras_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 200;

    // Bus flag sets for event items: start sent, address acked, tx empty, rx full.
    localparam logic [3:0] EV_NONE = 4'b0000;
    localparam logic [3:0] EV_SB   = 4'b1000;
    localparam logic [3:0] EV_ADDR = 4'b0100;
    localparam logic [3:0] EV_TXE  = 4'b0010;
    localparam logic [3:0] EV_RXNE = 4'b0001;

    // Transfer phases of the sequencer as tracked by the scoreboard.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SEND_DEV,
        SEQ_SEND_REG,
        SEQ_AFTER_REG,
        SEQ_SEND_DEVR,
        SEQ_RD_ADDR,
        SEQ_RD_DATA
    } t_seq_phase;

    // Tracks the transfer state and holds the bus actions still to come out.
    class t_action_scoreboard;
        t_seq_phase phase;
        bit         rd_mode;
        bit         active;
        logic [7:0] dev_byte;
        logic [7:0] reg_ptr;
        logic [7:0] bytes_left;
        logic [7:0] store_ptr;
        logic [7:0] store [256];
        bit         written [256];
        t_result    pending_actions [$];
        int         mismatches;

        function new();
            phase      = SEQ_IDLE;
            rd_mode    = 1'b0;
            active     = 1'b0;
            dev_byte   = 8'd0;
            reg_ptr    = 8'd0;
            bytes_left = 8'd0;
            store_ptr  = 8'd0;
            mismatches = 0;
        endfunction

        // True when the next tx empty event would send a store slot never loaded.
        function bit store_slot_unwritten(output logic [7:0] slot);
            slot = store_ptr;
            return active && phase == SEQ_AFTER_REG && !rd_mode && bytes_left != 8'd0
                && !written[store_ptr];
        endfunction

        // Sets the bus flag that moves the current phase forward.
        function t_item with_advancing_flag(input t_item it);
            case (phase)
                SEQ_SEND_DEV, SEQ_SEND_DEVR: it.flag_start_sent = 1'b1;
                SEQ_SEND_REG, SEQ_RD_ADDR:   it.flag_addr_acked = 1'b1;
                SEQ_AFTER_REG:               it.flag_tx_empty   = 1'b1;
                SEQ_RD_DATA:                 it.flag_rx_full    = 1'b1;
                default: ;
            endcase
            return it;
        endfunction

        // Works out the bus action of one accepted item and queues it.
        function void note_input(input t_item it);
            t_result r;
            r = '0;
            case (it.cmd)
                CMD_START_WRITE, CMD_START_READ: begin
                    dev_byte   = it.dev_addr;
                    reg_ptr    = it.reg_addr;
                    bytes_left = it.length;
                    store_ptr  = 8'd0;
                    rd_mode    = (it.cmd == CMD_START_READ);
                    phase      = SEQ_SEND_DEV;
                    active     = 1'b1;
                    r.gen_start = 1'b1;
                end
                CMD_LOAD_BYTE: begin
                    store[it.load_index]   = it.load_byte;
                    written[it.load_index] = 1'b1;
                end
                default: begin
                    if (active) begin
                        case (phase)
                            SEQ_SEND_DEV: if (it.flag_start_sent) begin
                                r.send_valid = 1'b1;
                                r.send_data  = dev_byte;
                                phase = SEQ_SEND_REG;
                            end
                            SEQ_SEND_REG: if (it.flag_addr_acked) begin
                                r.clear_addr = 1'b1;
                                r.send_valid = 1'b1;
                                r.send_data  = reg_ptr;
                                phase = SEQ_AFTER_REG;
                            end
                            SEQ_AFTER_REG: if (it.flag_tx_empty) begin
                                if (rd_mode) begin
                                    r.gen_start = 1'b1;
                                    phase = SEQ_SEND_DEVR;
                                end else if (bytes_left != 8'd0) begin
                                    r.send_valid = 1'b1;
                                    r.send_data  = store[store_ptr];
                                    store_ptr  = store_ptr + 8'd1;
                                    bytes_left = bytes_left - 8'd1;
                                    // More bytes: next register, new START.
                                    if (bytes_left != 8'd0) begin
                                        reg_ptr = reg_ptr + 8'd1;
                                        phase = SEQ_SEND_DEV;
                                        r.gen_start = 1'b1;
                                    end
                                end else begin
                                    // Last byte has left the shifter: close the write.
                                    r.gen_stop   = 1'b1;
                                    r.write_done = 1'b1;
                                    phase  = SEQ_IDLE;
                                    active = 1'b0;
                                end
                            end
                            SEQ_SEND_DEVR: if (it.flag_start_sent) begin
                                r.send_valid = 1'b1;
                                r.send_data  = dev_byte | 8'h01;
                                phase = SEQ_RD_ADDR;
                            end
                            SEQ_RD_ADDR: if (it.flag_addr_acked) begin
                                r.clear_addr = 1'b1;
                                phase = SEQ_RD_DATA;
                            end
                            SEQ_RD_DATA: if (it.flag_rx_full) begin
                                if (bytes_left == 8'd1) r.nack_next = 1'b1;
                                if (bytes_left != 8'd0) begin
                                    r.rx_valid = 1'b1;
                                    r.rx_data  = it.rx_byte;
                                    bytes_left = bytes_left - 8'd1;
                                end
                                if (bytes_left == 8'd0) begin
                                    r.gen_stop  = 1'b1;
                                    r.read_done = 1'b1;
                                    phase  = SEQ_IDLE;
                                    active = 1'b0;
                                end else begin
                                    reg_ptr = reg_ptr + 8'd1;
                                    phase = SEQ_SEND_DEV;
                                    r.gen_start = 1'b1;
                                end
                            end
                            default: begin
                                phase  = SEQ_IDLE;
                                active = 1'b0;
                            end
                        endcase
                    end
                end
            endcase
            r.busy_res = active;
            pending_actions.push_back(r);
        endfunction

        function string field_diff(string fname, logic [7:0] want, logic [7:0] got);
            if (got !== want) return $sformatf(" %s exp %0h got %0h", fname, want, got);
            return "";
        endfunction

        // Compares one accepted result item with the oldest queued action.
        function void check_result(input t_result got);
            t_result want;
            string   diffs;
            if (pending_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result item with nothing expected: %h", got);
                return;
            end
            want  = pending_actions.pop_front();
            diffs = {field_diff("gen_start", 8'(want.gen_start), 8'(got.gen_start)),
                     field_diff("gen_stop", 8'(want.gen_stop), 8'(got.gen_stop)),
                     field_diff("send_valid", 8'(want.send_valid), 8'(got.send_valid)),
                     field_diff("send_data", want.send_data, got.send_data),
                     field_diff("clear_addr", 8'(want.clear_addr), 8'(got.clear_addr)),
                     field_diff("nack_next", 8'(want.nack_next), 8'(got.nack_next)),
                     field_diff("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid)),
                     field_diff("rx_data", want.rx_data, got.rx_data),
                     field_diff("write_done", 8'(want.write_done), 8'(got.write_done)),
                     field_diff("read_done", 8'(want.read_done), 8'(got.read_done)),
                     field_diff("busy_res", 8'(want.busy_res), 8'(got.busy_res))};
            if (diffs != "") begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch at %0t:%s", $realtime, diffs);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_cmd;
    logic [7:0] i_dev_addr;
    logic [7:0] i_reg_addr;
    logic [7:0] i_length;
    logic [7:0] i_load_index;
    logic [7:0] i_load_byte;
    logic       i_flag_start_sent;
    logic       i_flag_addr_acked;
    logic       i_flag_tx_empty;
    logic       i_flag_rx_full;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall;
    logic       o_gen_start;
    logic       o_gen_stop;
    logic       o_send_valid;
    logic [7:0] o_send_data;
    logic       o_clear_addr;
    logic       o_nack_next;
    logic       o_rx_valid;
    logic [7:0] o_rx_data;
    logic       o_write_done;
    logic       o_read_done;
    logic       o_busy_res;

    t_action_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_left;

    i2c_register_access_sequencer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_dev_addr        (i_dev_addr),
        .i_reg_addr        (i_reg_addr),
        .i_length          (i_length),
        .i_load_index      (i_load_index),
        .i_load_byte       (i_load_byte),
        .i_flag_start_sent (i_flag_start_sent),
        .i_flag_addr_acked (i_flag_addr_acked),
        .i_flag_tx_empty   (i_flag_tx_empty),
        .i_flag_rx_full    (i_flag_rx_full),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_gen_start       (o_gen_start),
        .o_gen_stop        (o_gen_stop),
        .o_send_valid      (o_send_valid),
        .o_send_data       (o_send_data),
        .o_clear_addr      (o_clear_addr),
        .o_nack_next       (o_nack_next),
        .o_rx_valid        (o_rx_valid),
        .o_rx_data         (o_rx_data),
        .o_write_done      (o_write_done),
        .o_read_done       (o_read_done),
        .o_busy_res        (o_busy_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Every field random; callers then pick the command and the meaningful fields.
    function automatic t_item random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_item)-1:0];
    endfunction

    function automatic t_item start_item(logic [1:0] cmd, logic [7:0] dev, logic [7:0] regn,
                                         logic [7:0] len);
        t_item it;
        it = random_item();
        it.cmd      = cmd;
        it.dev_addr = dev;
        it.reg_addr = regn;
        it.length   = len;
        return it;
    endfunction

    function automatic t_item load_item(logic [7:0] idx, logic [7:0] data);
        t_item it;
        it = random_item();
        it.cmd        = CMD_LOAD_BYTE;
        it.load_index = idx;
        it.load_byte  = data;
        return it;
    endfunction

    function automatic t_item event_item(logic [3:0] flags, logic [7:0] rx);
        t_item it;
        it = random_item();
        it.cmd = CMD_BUS_EVENT;
        {it.flag_start_sent, it.flag_addr_acked, it.flag_tx_empty, it.flag_rx_full} = flags;
        it.rx_byte = rx;
        return it;
    endfunction

    // Mostly short transfers, now and then one of any length.
    function automatic logic [7:0] random_length();
        int r;
        r = $urandom_range(99);
        if (r < 75) return 8'($urandom_range(3));
        if (r < 95) return 8'($urandom_range(16, 4));
        return 8'($urandom_range(255));
    endfunction

    // Next random item, steered by the tracked state so transfers run to the end.
    function automatic t_item next_random_item();
        t_item it;
        int    pick;
        it   = random_item();
        pick = $urandom_range(99);
        if (!sb.active) begin
            if (pick < 55) begin
                it.cmd    = $urandom_range(1) ? CMD_START_READ : CMD_START_WRITE;
                it.length = random_length();
            end else if (pick < 80) begin
                it.cmd = CMD_LOAD_BYTE;
                if ($urandom_range(1)) it.load_index = 8'($urandom_range(7));
            end else begin
                it.cmd = CMD_BUS_EVENT;
            end
        end else if (pick < 6) begin
            // Restart in the middle of a transfer.
            it.cmd    = $urandom_range(1) ? CMD_START_READ : CMD_START_WRITE;
            it.length = random_length();
        end else if (pick < 14) begin
            it.cmd = CMD_LOAD_BYTE;
            if ($urandom_range(1)) it.load_index = 8'($urandom_range(7));
        end else begin
            it.cmd = CMD_BUS_EVENT;
            if (pick < 90) it = sb.with_advancing_flag(it);
        end
        return it;
    endfunction

    task automatic drive_payload(input t_item it);
        i_cmd             <= it.cmd;
        i_dev_addr        <= it.dev_addr;
        i_reg_addr        <= it.reg_addr;
        i_length          <= it.length;
        i_load_index      <= it.load_index;
        i_load_byte       <= it.load_byte;
        i_flag_start_sent <= it.flag_start_sent;
        i_flag_addr_acked <= it.flag_addr_acked;
        i_flag_tx_empty   <= it.flag_tx_empty;
        i_flag_rx_full    <= it.flag_rx_full;
        i_rx_byte         <= it.rx_byte;
    endtask

    // Offers one item, after random idle cycles, and holds it until accepted.
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        drive_payload(it);
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_input(it);
    endtask

    // Sends an item, first loading the store slot a write is about to send if needed.
    task automatic issue(input t_item it);
        logic [7:0] slot;
        if (sb.store_slot_unwritten(slot))
            send_item(load_item(slot, 8'($urandom)));
        send_item(it);
    endtask

    task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                             input int hold_at);
        t_item it;
        int    counted;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        counted = 0;
        while (counted < n_items) begin
            if (counted == hold_at) rx_hold_left = HOLD_CYCLES;
            it = next_random_item();
            // Events while idle are ignored by the block and do not count.
            if (!(it.cmd == CMD_BUS_EVENT && !sb.active)) counted++;
            issue(it);
        end
    endtask

    // Result side: check accepted items, then choose the stall for the next cycle.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
                sb.check_result({o_gen_start, o_gen_stop, o_send_valid, o_send_data,
                                 o_clear_addr, o_nack_next, o_rx_valid, o_rx_data,
                                 o_write_done, o_read_done, o_busy_res});
            if (rx_hold_left > 0) begin
                i_stall <= 1'b1;
                rx_hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("i2c_register_access_sequencer_test: done, errors");
        $finish;
    end

    initial begin
        sb = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        drive_payload('0);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bus event while idle is ignored.
        issue(event_item(EV_SB | EV_ADDR | EV_TXE | EV_RXNE, 8'hFF));

        // Two-byte write from the top register: the register address wraps to zero.
        issue(load_item(8'd0, 8'hFF));
        issue(load_item(8'd1, 8'h00));
        issue(start_item(CMD_START_WRITE, 8'hFE, 8'hFF, 8'd2));
        issue(event_item(EV_ADDR | EV_TXE | EV_RXNE, 8'h00));
        issue(event_item(EV_SB, 8'h00));
        issue(event_item(EV_ADDR, 8'h00));
        issue(event_item(EV_TXE, 8'h00));
        issue(event_item(EV_SB, 8'h00));
        issue(event_item(EV_ADDR, 8'h00));
        issue(event_item(EV_TXE, 8'h00));
        issue(event_item(EV_TXE, 8'h00));

        // Single-byte read: the only byte is answered with NACK.
        issue(start_item(CMD_START_READ, 8'h00, 8'h00, 8'd1));
        issue(event_item(EV_SB, 8'h00));
        issue(event_item(EV_ADDR, 8'h00));
        issue(event_item(EV_TXE, 8'h00));
        issue(event_item(EV_SB, 8'h00));
        issue(event_item(EV_ADDR, 8'h00));
        issue(event_item(EV_RXNE, 8'hFF));

        // A long read replaced at once by a zero-length read.
        issue(start_item(CMD_START_READ, 8'h55, 8'hAA, 8'hFF));
        issue(start_item(CMD_START_READ, 8'hAA, 8'h55, 8'h00));
        issue(event_item(EV_SB, 8'h00));
        issue(event_item(EV_ADDR, 8'h00));
        issue(event_item(EV_TXE, 8'h00));
        issue(event_item(EV_SB, 8'h00));
        issue(event_item(EV_ADDR, 8'h00));
        issue(event_item(EV_RXNE, 8'h3C));

        // Random traffic under each idling pattern; the first phase also backs up the block.
        run_phase(160, 0, 0, 60);
        run_phase(160, 79, 0, -1);
        run_phase(160, 0, 79, -1);
        run_phase(170, 27, 27, -1);
        i_valid <= 1'b0;

        while (sb.pending_actions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("i2c_register_access_sequencer_test: done, clean");
        else
            $display("i2c_register_access_sequencer_test: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/i2c_ras_pkg.sv
rtl/i2c_ras_store.sv
rtl/i2c_ras_ctrl.sv
rtl/i2c_register_access_sequencer.sv
bench/i2c_register_access_sequencer_test.sv
